// File: rtl/ssoa_pkg.sv
// Shared types and constants of the sweep-scan obstacle avoider.
// Mode, motor, LED and buzzer codes, command characters, register indexes
// and the packed result item. No dependencies.
package ssoa_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SCAN    = 3'd1,
    MODE_DECIDE  = 3'd2,
    MODE_MOVE    = 3'd3,
    MODE_ALERT   = 3'd4,
    MODE_REVERSE = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    MOT_NONE  = 3'd0,
    MOT_STOP  = 3'd1,
    MOT_FWD   = 3'd2,
    MOT_BACK  = 3'd3,
    MOT_LEFT  = 3'd4,
    MOT_RIGHT = 3'd5
  } motor_e;

  typedef enum logic [2:0] {
    LED_OFF       = 3'd0,
    LED_GREEN     = 3'd1,
    LED_RED       = 3'd2,
    LED_ORANGE    = 3'd3,
    LED_UNCHANGED = 3'd4
  } led_e;

  typedef enum logic [1:0] {
    BUZZ_NONE    = 2'd0,
    BUZZ_STOP    = 2'd1,
    BUZZ_ALERT   = 2'd2,
    BUZZ_REVERSE = 2'd3
  } buzz_e;

  // lower-case command characters; OR with CaseBit folds upper case
  localparam logic [7:0] CmdStart  = 8'h74;
  localparam logic [7:0] CmdStop   = 8'h78;
  localparam logic [7:0] CmdFwd    = 8'h77;
  localparam logic [7:0] CmdBack   = 8'h73;
  localparam logic [7:0] CmdLeft   = 8'h61;
  localparam logic [7:0] CmdRight  = 8'h64;
  localparam logic [7:0] CmdCenter = 8'h72;
  localparam logic [7:0] CaseBit   = 8'h20;

  localparam logic [2:0] CfgSafeDist    = 3'd0;
  localparam logic [2:0] CfgScanIntv    = 3'd1;
  localparam logic [2:0] CfgAvoidTime   = 3'd2;
  localparam logic [2:0] CfgSweepMin    = 3'd3;
  localparam logic [2:0] CfgSweepMax    = 3'd4;
  localparam logic [2:0] CfgSweepStep   = 3'd5;
  localparam logic [2:0] CfgCenterAngle = 3'd6;

  localparam logic [9:0]  RstSafeDist    = 10'd20;
  localparam logic [9:0]  RstScanIntv    = 10'd40;
  localparam logic [11:0] RstAvoidTime   = 12'd120;
  localparam logic [7:0]  RstSweepMin    = 8'd30;
  localparam logic [7:0]  RstSweepMax    = 8'd150;
  localparam logic [6:0]  RstSweepStep   = 7'd10;
  localparam logic [7:0]  RstCenterAngle = 8'd90;

  localparam logic [9:0]  NearestReset   = 10'd999;
  localparam logic [7:0]  RstSweepAngle  = 8'd30;
  localparam logic [7:0]  RstNearAngle   = 8'd90;
  localparam logic [7:0]  RstServoAngle  = 8'd90;

  typedef struct packed {
    logic [9:0]  safe_distance;
    logic [9:0]  scan_interval_ms;
    logic [11:0] avoid_time_ms;
    logic [7:0]  sweep_min;
    logic [7:0]  sweep_max;
    logic [6:0]  sweep_step;
    logic [7:0]  center_angle;
  } cfg_t;

  // packed from the last output field down, so mode_out sits in the lowest bits
  typedef struct packed {
    logic [7:0] nearest_angle_out;
    logic [9:0] nearest_dist_out;
    logic       scan_fired;
    buzz_e      buzzer_cmd;
    led_e       led_color;
    logic [7:0] servo_angle_out;
    motor_e     motor_cmd;
    mode_e      mode_out;
  } result_t;

endpackage

// File: rtl/ssoa_ctrl.sv
// Mode controller of the obstacle avoider: state registers and the
// single-pass update for one tick or command item.
// Depends on ssoa_pkg.
module ssoa_ctrl #(
  parameter int TIME_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ssoa_pkg::cfg_t   cfg_i,
  input  logic             accept_i,
  input  logic             action_i,
  input  logic [7:0]       cmd_byte_i,
  input  logic [9:0]       distance_cm_i,
  output ssoa_pkg::result_t result_o
);
  import ssoa_pkg::*;

  mode_e                 run_mode_q, run_mode_d;
  mode_e                 prev_mode_q, prev_mode_d;
  logic                  auto_q, auto_d;
  logic [7:0]            sweep_angle_q, sweep_angle_d;
  logic                  upward_q, upward_d;
  logic [9:0]            near_dist_q, near_dist_d;
  logic [7:0]            near_angle_q, near_angle_d;
  logic [TIME_WIDTH-1:0] ms_q, ms_d;
  logic [TIME_WIDTH-1:0] last_scan_q, last_scan_d;
  logic [TIME_WIDTH-1:0] avoid_start_q, avoid_start_d;
  logic                  avoiding_q, avoiding_d;
  logic [7:0]            servo_q, servo_d;

  always_comb begin
    logic [7:0]            cmd_lc;
    logic [TIME_WIDTH-1:0] scan_elapsed;
    logic [TIME_WIDTH-1:0] avoid_elapsed;
    logic signed [9:0]     next_angle;
    motor_e                motor;
    led_e                  led;
    buzz_e                 buzz;
    logic                  fired;

    run_mode_d    = run_mode_q;
    prev_mode_d   = prev_mode_q;
    auto_d        = auto_q;
    sweep_angle_d = sweep_angle_q;
    upward_d      = upward_q;
    near_dist_d   = near_dist_q;
    near_angle_d  = near_angle_q;
    ms_d          = ms_q;
    last_scan_d   = last_scan_q;
    avoid_start_d = avoid_start_q;
    avoiding_d    = avoiding_q;
    servo_d       = servo_q;
    motor         = MOT_NONE;
    led           = LED_UNCHANGED;
    buzz          = BUZZ_NONE;
    fired         = 1'b0;
    cmd_lc        = cmd_byte_i | CaseBit;
    scan_elapsed  = '0;
    avoid_elapsed = '0;
    next_angle    = '0;

    if (action_i) begin
      case (cmd_lc)
        CmdStart: begin
          auto_d = 1'b1; buzz = BUZZ_STOP; run_mode_d = MODE_SCAN;
        end
        CmdStop: begin
          auto_d = 1'b0; motor = MOT_STOP; buzz = BUZZ_STOP; run_mode_d = MODE_IDLE;
        end
        CmdFwd: begin
          auto_d = 1'b0; motor = MOT_FWD; buzz = BUZZ_STOP; run_mode_d = MODE_MOVE;
        end
        CmdBack: begin
          auto_d = 1'b0; motor = MOT_BACK; buzz = BUZZ_REVERSE;
          run_mode_d = MODE_REVERSE;
        end
        CmdLeft: begin
          auto_d = 1'b0; motor = MOT_LEFT; buzz = BUZZ_STOP;
        end
        CmdRight: begin
          auto_d = 1'b0; motor = MOT_RIGHT; buzz = BUZZ_STOP;
        end
        CmdCenter: begin
          servo_d = cfg_i.center_angle;
        end
        default: ;
      endcase
    end else begin
      ms_d = ms_q + {{(TIME_WIDTH-1){1'b0}}, 1'b1};
      case (run_mode_q)
        MODE_SCAN, MODE_MOVE: led = LED_GREEN;
        MODE_REVERSE:         led = LED_UNCHANGED;
        MODE_ALERT:           led = LED_RED;
        MODE_DECIDE:          led = LED_ORANGE;
        default:              led = LED_OFF;
      endcase
      if (run_mode_q != prev_mode_q) begin
        if (run_mode_q == MODE_REVERSE) begin
          motor = MOT_BACK;
        end else if (run_mode_q == MODE_ALERT) begin
          buzz = BUZZ_ALERT;
        end
        prev_mode_d = run_mode_q;
      end
      if (auto_q) begin
        case (run_mode_q)
          MODE_SCAN: begin
            scan_elapsed = ms_d - last_scan_q;
            if (scan_elapsed >= {{(TIME_WIDTH-10){1'b0}}, cfg_i.scan_interval_ms}) begin
              last_scan_d = ms_d;
              servo_d     = sweep_angle_q;
              fired       = 1'b1;
              if (distance_cm_i != 10'd0 && distance_cm_i < near_dist_q) begin
                near_dist_d  = distance_cm_i;
                near_angle_d = sweep_angle_q;
              end
              if (upward_q) begin
                next_angle = $signed({2'b00, sweep_angle_q}) + $signed({3'b000, cfg_i.sweep_step});
              end else begin
                next_angle = $signed({2'b00, sweep_angle_q}) - $signed({3'b000, cfg_i.sweep_step});
              end
              if (next_angle >= $signed({2'b00, cfg_i.sweep_max})) begin
                sweep_angle_d = cfg_i.sweep_max;
                upward_d      = 1'b0;
                run_mode_d    = MODE_DECIDE;
              end else if (next_angle <= $signed({2'b00, cfg_i.sweep_min})) begin
                sweep_angle_d = cfg_i.sweep_min;
                upward_d      = 1'b1;
                run_mode_d    = MODE_DECIDE;
              end else begin
                sweep_angle_d = next_angle[7:0];
              end
            end
          end
          MODE_DECIDE: begin
            run_mode_d = (near_dist_q > cfg_i.safe_distance) ? MODE_MOVE : MODE_ALERT;
          end
          MODE_MOVE: begin
            motor      = MOT_FWD;
            run_mode_d = MODE_SCAN;
          end
          MODE_REVERSE: begin
            motor = MOT_BACK;
          end
          MODE_ALERT: begin
            if (!avoiding_q) begin
              motor         = (near_angle_q < cfg_i.center_angle) ? MOT_RIGHT : MOT_LEFT;
              avoid_start_d = ms_d;
              avoiding_d    = 1'b1;
            end
            avoid_elapsed = ms_d - avoid_start_d;
            if (avoid_elapsed > {{(TIME_WIDTH-12){1'b0}}, cfg_i.avoid_time_ms}) begin
              motor       = MOT_STOP;
              avoiding_d  = 1'b0;
              near_dist_d = NearestReset;
              run_mode_d  = MODE_SCAN;
            end
          end
          default: ;
        endcase
      end
    end

    result_o.mode_out          = run_mode_d;
    result_o.motor_cmd         = motor;
    result_o.servo_angle_out   = servo_d;
    result_o.led_color         = led;
    result_o.buzzer_cmd        = buzz;
    result_o.scan_fired        = fired;
    result_o.nearest_dist_out  = near_dist_d;
    result_o.nearest_angle_out = near_angle_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q    <= MODE_IDLE;
      prev_mode_q   <= MODE_IDLE;
      auto_q        <= 1'b0;
      sweep_angle_q <= RstSweepAngle;
      upward_q      <= 1'b1;
      near_dist_q   <= NearestReset;
      near_angle_q  <= RstNearAngle;
      ms_q          <= '0;
      last_scan_q   <= '0;
      avoid_start_q <= '0;
      avoiding_q    <= 1'b0;
      servo_q       <= RstServoAngle;
    end else if (accept_i) begin
      run_mode_q    <= run_mode_d;
      prev_mode_q   <= prev_mode_d;
      auto_q        <= auto_d;
      sweep_angle_q <= sweep_angle_d;
      upward_q      <= upward_d;
      near_dist_q   <= near_dist_d;
      near_angle_q  <= near_angle_d;
      ms_q          <= ms_d;
      last_scan_q   <= last_scan_d;
      avoid_start_q <= avoid_start_d;
      avoiding_q    <= avoiding_d;
      servo_q       <= servo_d;
    end
  end

endmodule

// File: rtl/sweep_scan_obstacle_avoider.sv
// Top level of the sweep-scan obstacle avoider: configuration registers,
// stream ports and the result register around ssoa_ctrl.
// Depends on ssoa_pkg and ssoa_ctrl.
//
//   channel   | direction | payload
//   s_axis    | in        | tuser: action; tdata: cmd_byte, distance_cm
//   m_axis    | out       | tdata: mode, motor, servo, led, buzzer, fired, dist, angle
//   cfg       | in        | cfg_addr_i register index, cfg_data_i value
//
// One item per cycle while s_axis_tready is high; its result is in the output
// register in the cycle after acceptance. State updates in the same edge that
// accepts the item. s_axis_tready drops only while the output register
// is full and not taken. Reset loads the register defaults and all state but out_q.
module sweep_scan_obstacle_avoider #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [11:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // cmd_byte[7:0], distance_cm[17:8], zero
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // mode_out[2:0], motor_cmd[5:3],
                                      // servo_angle_out[13:6], led_color[16:14],
                                      // buzzer_cmd[18:17], scan_fired[19],
                                      // nearest_dist_out[29:20],
                                      // nearest_angle_out[37:30], zero
);
  import ssoa_pkg::*;

  cfg_t    cfg_q;
  result_t result_d, out_q;
  logic    out_valid_q;
  logic    in_acc;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.safe_distance    <= RstSafeDist;
      cfg_q.scan_interval_ms <= RstScanIntv;
      cfg_q.avoid_time_ms    <= RstAvoidTime;
      cfg_q.sweep_min        <= RstSweepMin;
      cfg_q.sweep_max        <= RstSweepMax;
      cfg_q.sweep_step       <= RstSweepStep;
      cfg_q.center_angle     <= RstCenterAngle;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgSafeDist:    cfg_q.safe_distance    <= cfg_data_i[9:0];
        CfgScanIntv:    cfg_q.scan_interval_ms <= cfg_data_i[9:0];
        CfgAvoidTime:   cfg_q.avoid_time_ms    <= cfg_data_i;
        CfgSweepMin:    cfg_q.sweep_min        <= cfg_data_i[7:0];
        CfgSweepMax:    cfg_q.sweep_max        <= cfg_data_i[7:0];
        CfgSweepStep:   cfg_q.sweep_step       <= cfg_data_i[6:0];
        CfgCenterAngle: cfg_q.center_angle     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  ssoa_ctrl #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (in_acc),
    .action_i     (s_axis_tuser),
    .cmd_byte_i   (s_axis_tdata[7:0]),
    .distance_cm_i(s_axis_tdata[17:8]),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

  a_cmd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser |=> out_q.led_color == LED_UNCHANGED && !out_q.scan_fired)
    else $error("command item produced tick-only result fields");

  a_nearest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.nearest_dist_out <= NearestReset)
    else $error("nearest distance above its reset value");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

endmodule
